// ===== rtl/core/fta_pkg.sv =====
// Shared types and constants for the frame table allocator.
`default_nettype none

package fta_pkg;

  // Number of segment size fields carried by one request.
  localparam int SizeFields = 5;

  // Command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_GRANTED  = 2'd0;
  localparam logic [1:0] STAT_REFUSED  = 2'd1;
  localparam logic [1:0] STAT_RELEASED = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] owner_id;
    logic [3:0] request_count;
    logic [1:0] seg_size_a;
    logic [1:0] seg_size_b;
    logic [1:0] seg_size_c;
    logic [1:0] seg_size_d;
    logic [1:0] seg_size_e;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] frame_mask;
    logic [5:0]  frames_touched;
  } out_item_t;

  // What one scan over the frame table does.
  typedef enum logic [1:0] {
    PASS_ANALYZE = 2'd0,  // read only: find frames to take
    PASS_GRANT   = 2'd1,  // write owner into chosen frames
    PASS_FREE    = 2'd2   // clear the owner's frames and chosen frames
  } pass_kind_t;

  typedef struct packed {
    logic       load_item;
    logic       start_pass;
    pass_kind_t pass_kind;
    logic       set_status;
    logic [1:0] status;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic who_zero;
    logic too_many;
    logic paging;
    logic pass_done;
    logic fit_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fta_datapath.sv =====
// Frame table memory, scan pipeline, placement logic and result register.
`default_nettype none

module fta_datapath #(
  parameter int FRAMES       = 32,
  parameter int MAX_SEGMENTS = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_data,
  input  wire fta_pkg::in_item_t  in_data,
  input  wire fta_pkg::ctrl_cmd_t cmd,
  output fta_pkg::dp_status_t     sts,
  output fta_pkg::out_item_t      out_data
);

  localparam int AW = $clog2(FRAMES);
  localparam logic [AW-1:0] LastFrame = AW'(FRAMES - 1);

  // frame table
  logic [7:0]        mem_r [FRAMES];
  logic [FRAMES-1:0] vld_r;
  logic [7:0]        rd_data_r;
  logic              rd_vld_r;

  logic              paging_mode_r;
  fta_pkg::in_item_t item_r;

  // scan pipeline
  logic                issue_r;
  logic [AW-1:0]       addr_r;
  logic                pv_r;
  logic [AW-1:0]       pf_r;
  fta_pkg::pass_kind_t kind_r;

  // placement state
  logic [FRAMES-1:0] placed_r, placed_nxt;
  logic [FRAMES-1:0] pend_r, pend_nxt;
  logic [2:0]        seg_r, seg_nxt;
  logic [1:0]        run_r, run_nxt;
  logic [3:0]        taken_r, taken_nxt;

  logic [31:0] mask_r, mask_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  status_r;
  fta_pkg::out_item_t out_r;

  logic              wr_en;
  logic [7:0]        wr_data;
  logic              touch;
  logic [7:0]        owner;
  logic              frame_free;
  logic [FRAMES-1:0] frame_bit;
  logic [2:0]        seg_cur;
  logic              seg_active;
  logic [1:0]        cur_size;
  logic [3:0]        want;

  function automatic logic [1:0] size_at(input fta_pkg::in_item_t it, input logic [2:0] idx);
    logic [1:0] s;
    unique case (idx)
      3'd0:    s = it.seg_size_a;
      3'd1:    s = it.seg_size_b;
      3'd2:    s = it.seg_size_c;
      3'd3:    s = it.seg_size_d;
      3'd4:    s = it.seg_size_e;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  // Step past zero-size segments, which are placed without taking a frame.
  function automatic logic [2:0] seg_skip(input fta_pkg::in_item_t it, input logic [2:0] start);
    logic [2:0] s;
    s = start;
    for (int k = 0; k < fta_pkg::SizeFields; k++) begin
      if (({1'b0, s} < it.request_count) && (size_at(it, s) == 2'd0)) begin
        s = s + 3'd1;
      end
    end
    return s;
  endfunction

  assign want       = item_r.request_count;
  assign owner      = rd_vld_r ? rd_data_r : 8'd0;
  assign frame_free = (owner == 8'd0);
  assign frame_bit  = FRAMES'(1) << pf_r;
  assign seg_cur    = seg_skip(item_r, seg_r);
  assign seg_active = ({1'b0, seg_cur} < want);
  assign cur_size   = size_at(item_r, seg_cur);

  always_comb begin
    placed_nxt = placed_r;
    pend_nxt   = pend_r;
    seg_nxt    = seg_r;
    run_nxt    = run_r;
    taken_nxt  = taken_r;
    mask_nxt   = mask_r;
    cnt_nxt    = cnt_r;
    wr_en      = 1'b0;
    wr_data    = 8'd0;
    touch      = 1'b0;
    if (cmd.load_item) begin
      placed_nxt = '0;
      pend_nxt   = '0;
      seg_nxt    = 3'd0;
      run_nxt    = 2'd0;
      taken_nxt  = 4'd0;
      mask_nxt   = 32'd0;
      cnt_nxt    = 6'd0;
    end else if (pv_r) begin
      unique case (kind_r)
        fta_pkg::PASS_ANALYZE: begin
          if (paging_mode_r) begin
            // first free frames, as many as requested
            if (frame_free && (taken_r < want)) begin
              placed_nxt = placed_r | frame_bit;
              taken_nxt  = taken_r + 4'd1;
            end
          end else if (seg_active) begin
            if (frame_free) begin
              if ((run_r + 2'd1) == cur_size) begin
                placed_nxt = placed_r | pend_r | frame_bit;
                pend_nxt   = '0;
                run_nxt    = 2'd0;
                seg_nxt    = seg_cur + 3'd1;
              end else begin
                pend_nxt = pend_r | frame_bit;
                run_nxt  = run_r + 2'd1;
                seg_nxt  = seg_cur;
              end
            end else begin
              // occupied frame breaks the run
              pend_nxt = '0;
              run_nxt  = 2'd0;
              seg_nxt  = seg_cur;
            end
          end
        end
        fta_pkg::PASS_GRANT: begin
          if (placed_r[pf_r]) begin
            wr_en   = 1'b1;
            wr_data = item_r.owner_id;
            touch   = 1'b1;
          end
        end
        fta_pkg::PASS_FREE: begin
          if ((owner == item_r.owner_id) || placed_r[pf_r]) begin
            wr_en   = 1'b1;
            wr_data = 8'd0;
            touch   = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (touch) begin
        mask_nxt = mask_r | (32'd1 << pf_r);
        cnt_nxt  = (cnt_r == 6'd63) ? cnt_r : cnt_r + 6'd1;
      end
    end
  end

  // table storage; synchronous read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[pf_r] <= wr_data;
    end
    rd_data_r <= mem_r[addr_r];
    rd_vld_r  <= vld_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r         <= '0;
      paging_mode_r <= 1'b0;
      issue_r       <= 1'b0;
      pv_r          <= 1'b0;
      mask_r        <= 32'd0;
      cnt_r         <= 6'd0;
    end else begin
      if (wr_en) begin
        vld_r[pf_r] <= 1'b1;
      end
      if (cfg_we) begin
        paging_mode_r <= cfg_data;
      end
      pv_r <= issue_r;
      if (cmd.start_pass) begin
        issue_r <= 1'b1;
      end else if (issue_r && (addr_r == LastFrame)) begin
        issue_r <= 1'b0;
      end
      mask_r <= mask_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pf_r <= addr_r;
    if (cmd.start_pass) begin
      addr_r <= '0;
      kind_r <= cmd.pass_kind;
    end else if (issue_r && (addr_r != LastFrame)) begin
      addr_r <= addr_r + AW'(1);
    end
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    placed_r <= placed_nxt;
    pend_r   <= pend_nxt;
    seg_r    <= seg_nxt;
    run_r    <= run_nxt;
    taken_r  <= taken_nxt;
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.load_out) begin
      out_r.status         <= status_r;
      out_r.frame_mask     <= mask_r;
      out_r.frames_touched <= cnt_r;
    end
  end

  assign sts.is_release = (item_r.cmd == fta_pkg::CMD_RELEASE);
  assign sts.who_zero   = (item_r.owner_id == 8'd0);
  assign sts.too_many   = (32'(want) > 32'(MAX_SEGMENTS)) ||
                          (32'(want) > 32'(fta_pkg::SizeFields));
  assign sts.paging     = paging_mode_r;
  assign sts.pass_done  = pv_r && (pf_r == LastFrame);
  assign sts.fit_ok     = paging_mode_r ? (taken_r == want) : !seg_active;

  assign out_data = out_r;

  // a grant never lands on an occupied frame
  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r && (kind_r == fta_pkg::PASS_GRANT) && placed_r[pf_r]) |-> frame_free)
    else $error("grant writes an occupied frame");

  // reported frames only change while a committing pass runs or an item is loaded
  a_mask_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.load_item && !(pv_r && (kind_r != fta_pkg::PASS_ANALYZE))) |=> $stable(mask_r))
    else $error("frame mask changed outside a commit pass");

endmodule

`default_nettype wire

// ===== rtl/core/fta_ctrl.sv =====
// Sequencing state machine for the frame table allocator.
`default_nettype none

module fta_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire fta_pkg::dp_status_t sts,
  output fta_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CHECK   = 6'b000010,
    ST_ANALYZE = 6'b000100,
    ST_EVAL    = 6'b001000,
    ST_COMMIT  = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.pass_kind  = fta_pkg::PASS_ANALYZE;
    cmd.status     = fta_pkg::STAT_GRANTED;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.set_status = 1'b1;
        priority if (sts.is_release) begin
          cmd.status = fta_pkg::STAT_RELEASED;
          if (sts.who_zero) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.start_pass = 1'b1;
            cmd.pass_kind  = fta_pkg::PASS_FREE;
            state_nxt      = ST_COMMIT;
          end
        end else if (sts.who_zero || (!sts.paging && sts.too_many)) begin
          cmd.status = fta_pkg::STAT_REFUSED;
          state_nxt  = ST_FINISH;
        end else begin
          cmd.start_pass = 1'b1;
          cmd.pass_kind  = fta_pkg::PASS_ANALYZE;
          state_nxt      = ST_ANALYZE;
        end
      end
      ST_ANALYZE: begin
        if (sts.pass_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.set_status = 1'b1;
        priority if (sts.fit_ok) begin
          cmd.status     = fta_pkg::STAT_GRANTED;
          cmd.start_pass = 1'b1;
          cmd.pass_kind  = fta_pkg::PASS_GRANT;
          state_nxt      = ST_COMMIT;
        end else if (sts.paging) begin
          cmd.status = fta_pkg::STAT_REFUSED;
          state_nxt  = ST_FINISH;
        end else begin
          // failed segment placement frees everything the owner holds
          cmd.status     = fta_pkg::STAT_REFUSED;
          cmd.start_pass = 1'b1;
          cmd.pass_kind  = fta_pkg::PASS_FREE;
          state_nxt      = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.pass_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CHECK))
    else $error("accepted item not followed by check");

  a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pass_done |-> ((state_r == ST_ANALYZE) || (state_r == ST_COMMIT)))
    else $error("scan finished outside a pass state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending result");

endmodule

`default_nettype wire

// ===== rtl/core/frame_table_allocator_unit.sv =====
// Top level of the first-fit frame table allocator.
// A release runs a freeing scan; an allocation runs an analyzing scan, then
// a committing scan unless paging refuses it; refusals found up front skip both.
// Throughput: one item at a time; each scan reads one table frame per cycle
// through the single memory read port, so that port sets the item time.
// Reset (rst_n, synchronous, active low): every frame free, paging_mode 0,
// no result pending; the table clears at once through per-frame valid bits.
`default_nettype none

module frame_table_allocator_unit #(
  parameter int FRAMES       = 32,  // table depth, 2..32
  parameter int MAX_SEGMENTS = 5    // segment limit, 1..5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel: transfer when in_valid high and in_stall low
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fta_pkg::in_item_t  in_data,
  // result channel: transfer when out_valid high and out_stall low
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fta_pkg::out_item_t      out_data,
  // paging_mode register write: transfer when cfg_valid and cfg_ready high
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);

  fta_pkg::ctrl_cmd_t  cmd;
  fta_pkg::dp_status_t sts;

  // The user must write the register only while idle (not enforced here); the port never pushes back.
  assign cfg_ready = 1'b1;

  // Controller: check the request, run an analyzing scan (not for a release),
  // decide grant or refusal, run a committing scan if one is needed, then hand
  // the result to the output register once the previous result has been taken.
  fta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: frame owner memory, one-frame-per-cycle scan pipeline,
  // paging and segment placement, frame mask and count accumulation.
  fta_datapath #(
    .FRAMES       (FRAMES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for frame_table_allocator_unit.
`timescale 1ns / 1ps

module tb;

  localparam int FRAMES     = 32;
  localparam int MAX_SEG    = 5;
  localparam int IDLE_LIMIT = 4000;  // cycles without any transfer
  localparam int PHASES     = 5;
  localparam int PHASE_LEN  = 100;
  localparam int InBits     = $bits(fta_pkg::in_item_t);

  // short local names for the package codes
  localparam logic       CmdAlloc   = fta_pkg::CMD_ALLOC;
  localparam logic       CmdRelease = fta_pkg::CMD_RELEASE;
  localparam logic [1:0] StGranted  = fta_pkg::STAT_GRANTED;
  localparam logic [1:0] StRefused  = fta_pkg::STAT_REFUSED;
  localparam logic [1:0] StReleased = fta_pkg::STAT_RELEASED;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  fta_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fta_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data  = 1'b0;

  frame_table_allocator_unit #(
    .FRAMES      (FRAMES),
    .MAX_SEGMENTS(MAX_SEG)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow of the frame table and the mode register
  logic [7:0] owner_shadow [FRAMES];
  bit         paging_shadow;

  fta_pkg::out_item_t predicted_replies [$];
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  int                 burst_left;

  typedef struct {
    bit                 mode;
    fta_pkg::in_item_t  item;
    bit                 typed;
    fta_pkg::out_item_t res;
  } stim_row_t;

  stim_row_t  dir_rows [$];

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Clear every frame of one owner, marking them in the reply
  function automatic void free_owner_frames(input logic [7:0] who,
                                            inout fta_pkg::out_item_t res);
    int f;
    if (who == 8'd0) return;
    for (f = 0; f < FRAMES; f++) begin
      if (owner_shadow[f] == who) begin
        owner_shadow[f] = 8'd0;
        res.frame_mask[f] = 1'b1;
        res.frames_touched++;
      end
    end
  endfunction

  // Applies one request to the shadow table and returns the reply it owes
  function automatic fta_pkg::out_item_t predict_allocation(input fta_pkg::in_item_t it);
    fta_pkg::out_item_t res;
    logic [1:0]         sizes [fta_pkg::SizeFields];
    logic [7:0]         who;
    int                 f, k, seg, run, free_cnt, left, want;
    res = '0;
    who = it.owner_id;
    want = it.request_count;
    sizes[0] = it.seg_size_a;
    sizes[1] = it.seg_size_b;
    sizes[2] = it.seg_size_c;
    sizes[3] = it.seg_size_d;
    sizes[4] = it.seg_size_e;
    if (it.cmd == CmdRelease) begin
      free_owner_frames(who, res);
      res.status = StReleased;
    end else if (who == 8'd0) begin
      res.status = StRefused;
    end else if (paging_shadow) begin
      free_cnt = 0;
      for (f = 0; f < FRAMES; f++)
        if (owner_shadow[f] == 8'd0) free_cnt++;
      if (free_cnt < want) begin
        res.status = StRefused;
      end else begin
        res.status = StGranted;
        left = want;
        for (f = 0; f < FRAMES && left > 0; f++) begin
          if (owner_shadow[f] == 8'd0) begin
            owner_shadow[f] = who;
            res.frame_mask[f] = 1'b1;
            res.frames_touched++;
            left--;
          end
        end
      end
    end else if (want > MAX_SEG || want > fta_pkg::SizeFields) begin
      res.status = StRefused;
    end else begin
      // One forward scan; a free run restarts at each occupied frame
      res.status = StGranted;
      seg = 0;
      run = 0;
      for (f = 0; f < FRAMES; f++) begin
        while (seg < want && sizes[seg] == 2'd0) seg++;
        if (seg >= want) break;
        if (owner_shadow[f] == 8'd0) begin
          run++;
          if (run == sizes[seg]) begin
            for (k = 0; k < run; k++) begin
              owner_shadow[f - k] = who;
              res.frame_mask[f - k] = 1'b1;
              res.frames_touched++;
            end
            seg++;
            run = 0;
          end
        end else begin
          run = 0;
        end
      end
      while (seg < want && sizes[seg] == 2'd0) seg++;
      if (seg < want) begin
        // placement failed: report only what the cleanup frees
        res = '0;
        free_owner_frames(who, res);
        res.status = StRefused;
      end
    end
    return res;
  endfunction

  // sizes packs seg_size_a..seg_size_e, a in the top bits
  function automatic void add_row(input bit mode, input logic cmd, input logic [7:0] owner,
                                  input logic [3:0] cnt, input logic [9:0] sizes,
                                  input bit typed, input logic [1:0] st,
                                  input logic [31:0] mask, input logic [5:0] touched);
    stim_row_t row;
    row.mode  = mode;
    row.item  = {cmd, owner, cnt, sizes};
    row.typed = typed;
    row.res   = {st, mask, touched};
    dir_rows.push_back(row);
  endfunction

  task automatic send_request(input fta_pkg::in_item_t it, input bit use_typed,
                              input fta_pkg::out_item_t typed_res);
    int                 gap;
    fta_pkg::out_item_t predicted;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 40);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predicted = predict_allocation(it);
    predicted_replies.push_back(use_typed ? typed_res : predicted);
  endtask

  // Hold off the sender until every owed reply has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input bit mode);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    paging_shadow = mode;
  endtask

  function automatic void check_field(input string fname, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (actv !== expv) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, expv, actv);
    end
  endfunction

  // Result side: random stall with stretches of none
  initial begin : stall_gen
    int run_len;
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      repeat (run_len) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
      run_len = pick_gap() + 1;
      repeat (run_len) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : reply_check
    fta_pkg::out_item_t want_res;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply, got %h", $time, out_data);
      end else begin
        want_res = predicted_replies.pop_front();
        check_field("status", 32'(want_res.status), 32'(out_data.status));
        check_field("frame_mask", want_res.frame_mask, out_data.frame_mask);
        check_field("frames_touched", 32'(want_res.frames_touched),
                    32'(out_data.frames_touched));
      end
    end
  end

  // Watchdog: too long without any transfer on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    fta_pkg::in_item_t it;
    stim_row_t         row;
    int                i, phase, n, r;
    burst_left    = 0;
    paging_shadow = 1'b0;
    for (i = 0; i < FRAMES; i++) owner_shadow[i] = 8'd0;

    // Segment mode (reset value)
    add_row(0, CmdAlloc,   8'd0,   4'd1,  10'h300, 1, StRefused,  32'h0, 6'd0);
    add_row(0, CmdRelease, 8'd0,   4'd1,  10'h300, 1, StReleased, 32'h0, 6'd0);
    add_row(0, CmdAlloc,   8'd1,   4'd6,  10'h3FF, 1, StRefused,  32'h0, 6'd0);
    add_row(0, CmdAlloc,   8'd1,   4'd15, 10'h3FF, 1, StRefused,  32'h0, 6'd0);
    add_row(0, CmdAlloc,   8'd1,   4'd0,  10'h3FF, 1, StGranted,  32'h0, 6'd0);
    add_row(0, CmdAlloc,   8'd1,   4'd1,  10'h300, 1, StGranted,  32'h7, 6'd3);
    // zero-size first segment, then four of three frames
    add_row(0, CmdAlloc,   8'd2,   4'd5,  10'h0FF, 1, StGranted,  32'h7FF8, 6'd12);
    add_row(0, CmdAlloc,   8'd255, 4'd5,  10'h3FF, 0, StGranted,  32'h0, 6'd0);
    // no room, owner holds nothing
    add_row(0, CmdAlloc,   8'd3,   4'd1,  10'h300, 0, StGranted,  32'h0, 6'd0);
    add_row(0, CmdRelease, 8'd2,   4'd0,  10'h000, 0, StGranted,  32'h0, 6'd0);
    // owner already holds frames, gets more
    add_row(0, CmdAlloc,   8'd1,   4'd2,  10'h2C0, 0, StGranted,  32'h0, 6'd0);
    // two segments fit, the third fails: cleanup reported
    add_row(0, CmdAlloc,   8'd4,   4'd3,  10'h3F0, 0, StGranted,  32'h0, 6'd0);
    add_row(0, CmdRelease, 8'd1,   4'd15, 10'h3FF, 0, StGranted,  32'h0, 6'd0);
    add_row(0, CmdRelease, 8'd255, 4'd0,  10'h000, 0, StGranted,  32'h0, 6'd0);
    add_row(0, CmdRelease, 8'd9,   4'd0,  10'h000, 1, StReleased, 32'h0, 6'd0);
    // Paging mode, table empty again
    add_row(1, CmdAlloc,   8'd0,   4'd4,  10'h000, 1, StRefused,  32'h0, 6'd0);
    add_row(1, CmdAlloc,   8'd5,   4'd0,  10'h000, 1, StGranted,  32'h0, 6'd0);
    add_row(1, CmdAlloc,   8'd5,   4'd10, 10'h000, 1, StGranted,  32'h3FF, 6'd10);
    add_row(1, CmdAlloc,   8'd6,   4'd10, 10'h3FF, 0, StGranted,  32'h0, 6'd0);
    add_row(1, CmdAlloc,   8'd7,   4'd10, 10'h155, 0, StGranted,  32'h0, 6'd0);
    add_row(1, CmdAlloc,   8'd8,   4'd3,  10'h000, 1, StRefused,  32'h0, 6'd0);
    add_row(1, CmdAlloc,   8'd8,   4'd2,  10'h2AA, 0, StGranted,  32'h0, 6'd0);
    add_row(1, CmdRelease, 8'd6,   4'd0,  10'h000, 0, StGranted,  32'h0, 6'd0);
    add_row(1, CmdAlloc,   8'd200, 4'd15, 10'h3FF, 0, StGranted,  32'h0, 6'd0);
    add_row(1, CmdRelease, 8'd255, 4'd0,  10'h000, 0, StGranted,  32'h0, 6'd0);

    // hold reset low, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.mode != paging_shadow) write_mode(row.mode);
      send_request(row.item, row.typed, row.res);
    end

    // Random part: small pool of owners so releases hit real frames
    for (phase = 0; phase < PHASES; phase++) begin
      write_mode((phase % 2) == 0);
      for (n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 49) == 0) drain_replies();
        it = InBits'($urandom());
        it.cmd = ($urandom_range(0, 99) < 35) ? CmdRelease : CmdAlloc;
        r = $urandom_range(0, 99);
        if (r < 85)      it.owner_id = 8'($urandom_range(1, 8));
        else if (r < 90) it.owner_id = 8'd0;
        else if (r < 93) it.owner_id = 8'd255;
        // remaining cases keep the raw random owner
        if ($urandom_range(0, 99) < 85)
          it.request_count = 4'(paging_shadow ? $urandom_range(1, 10)
                                              : $urandom_range(1, MAX_SEG));
        send_request(it, 1'b0, '0);
      end
    end

    drain_replies();
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fta_pkg.sv
rtl/core/fta_datapath.sv
rtl/core/fta_ctrl.sv
rtl/core/frame_table_allocator_unit.sv
tb/tb.sv
